[rtl/core/vtpc_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpc_pkg
// Shared types and constants for the value to palette color pipeline.
// ----------------------------------------------------------------------------
package vtpc_pkg;

	// Field widths.
	localparam int SAMPLE_W = 32;
	localparam int TOL_W    = 31;
	localparam int CNT_W    = 5;
	localparam int FRAC_W   = 16;
	localparam int QUOT_W   = CNT_W + FRAC_W;
	localparam int CFG_IDX_W = 2;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_BLACK_LEVEL = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TOLERANCE   = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_COLOR_COUNT = 2'd2;

	// Request functions.
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_MAP   = 1'b1;

	// Sample classes decided at the front of the pipeline.
	localparam logic [1:0] CLS_BLACK = 2'd0;
	localparam logic [1:0] CLS_LAST  = 2'd1;
	localparam logic [1:0] CLS_FIRST = 2'd2;
	localparam logic [1:0] CLS_BLEND = 2'd3;

	localparam logic [31:0] BLACK_WORD = 32'hFF00_0000;
	localparam logic [7:0]  ALPHA_OPAQUE = 8'hFF;

	typedef struct packed {
		logic        func;
		logic [3:0]  entry_index;
		logic [31:0] entry_color;
		logic signed [31:0] sample;
	} vtpc_in_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic [7:0] alpha;
	} vtpc_out_t;

	// Control that travels with every request down the pipeline.
	typedef struct packed {
		logic             vld;
		logic             wr;
		logic [3:0]       idx;
		logic [31:0]      color;
		logic [1:0]       cls;
		logic [CNT_W-1:0] last;
	} vtpc_ctl_t;

endpackage

[rtl/core/value_to_palette_color.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// value_to_palette_color
// Maps signed Q16.16 samples to RGBA pixels through a blended palette.
// ----------------------------------------------------------------------------
// The block takes one request on every clock and never raises busy. A map
// request gives its pixel on result with a one-cycle result_valid strobe;
// the receiver cannot stall it. The pipeline holds the position divider,
// which resolves one of its 21 quotient bits per stage, plus three front
// stages and two palette stages. Palette writes go down the same pipeline
// and give no result, so a map request always sees every write taken
// before it. Configuration writes are always ready and must only be made
// while no request is in flight.
module value_to_palette_color #(
	parameter int PALETTE_DEPTH = 16
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  vtpc_pkg::vtpc_in_t                   req,
	output logic                                 result_valid,
	output vtpc_pkg::vtpc_out_t                  result,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [vtpc_pkg::CFG_IDX_W-1:0]       cfg_index,
	input  logic [31:0]                          cfg_data
);
	import vtpc_pkg::*;

	logic signed [31:0] black_level_q;
	logic [TOL_W-1:0]   tolerance_q;
	logic [CNT_W-1:0]   color_count_q;

	vtpc_ctl_t         ctl_s3;
	logic [CNT_W+31:0] prod_s3;

	vtpc_ctl_t         div_ctl  [QUOT_W+1];
	logic [31:0]       div_rem  [QUOT_W+1];
	logic [QUOT_W-1:0] div_word [QUOT_W+1];

	assign busy      = 1'b0;
	assign cfg_ready = 1'b1;

	// Configuration registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			black_level_q <= 32'sh8000_0000;
			tolerance_q   <= 31'd65536;
			color_count_q <= 5'd2;
		end else if (cfg_valid) begin
			unique case (cfg_index)
				REG_BLACK_LEVEL: black_level_q <= cfg_data;
				REG_TOLERANCE:   tolerance_q   <= cfg_data[TOL_W-1:0];
				REG_COLOR_COUNT: color_count_q <= cfg_data[CNT_W-1:0];
				default:         ;
			endcase
		end
	end

	vtpc_front #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.take        (start),
		.req         (req),
		.black_level (black_level_q),
		.tolerance   (tolerance_q),
		.color_count (color_count_q),
		.ctl_s3      (ctl_s3),
		.prod_s3     (prod_s3)
	);

	// Divider chain: position * 65536 / (2 * tolerance).
	assign div_ctl[0]  = ctl_s3;
	assign div_rem[0]  = prod_s3[CNT_W+31:CNT_W];
	assign div_word[0] = {prod_s3[CNT_W-1:0], {FRAC_W{1'b0}}};

	for (genvar i = 0; i < QUOT_W; i++) begin : g_div
		vtpc_div_step u_step (
			.clk     (clk),
			.arst_n  (arst_n),
			.ctl_in  (div_ctl[i]),
			.rem_in  (div_rem[i]),
			.word_in (div_word[i]),
			.divisor ({tolerance_q, 1'b0}),
			.ctl_s1  (div_ctl[i+1]),
			.rem_s1  (div_rem[i+1]),
			.word_s1 (div_word[i+1])
		);
	end

	vtpc_palette #(.PALETTE_DEPTH(PALETTE_DEPTH)) u_palette (
		.clk          (clk),
		.arst_n       (arst_n),
		.ctl_in       (div_ctl[QUOT_W]),
		.quot         (div_word[QUOT_W]),
		.result_valid (result_valid),
		.result       (result)
	);

endmodule

[rtl/core/vtpc_front.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpc_front
// Input register, sample classification and the scaling multiply that
// forms the dividend of the position divider.
// ----------------------------------------------------------------------------
module vtpc_front #(
	parameter int PALETTE_DEPTH = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          take,
	input  vtpc_pkg::vtpc_in_t            req,
	input  logic signed [31:0]            black_level,
	input  logic [vtpc_pkg::TOL_W-1:0]    tolerance,
	input  logic [vtpc_pkg::CNT_W-1:0]    color_count,
	output vtpc_pkg::vtpc_ctl_t           ctl_s3,
	output logic [vtpc_pkg::CNT_W+31:0]   prod_s3
);
	import vtpc_pkg::*;

	localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

	logic             vld_s1;
	vtpc_in_t         req_s1;
	vtpc_ctl_t        ctl_s2;
	logic [31:0]      u_s2;
	logic [CNT_W-1:0] cnt_m1_s2;

	logic [CNT_W-1:0]   count;
	logic signed [32:0] s_ext;
	logic signed [32:0] tol_ext;
	logic signed [32:0] sum;
	logic [1:0]         cls;

	// Input register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= take;
		end
	end

	always_ff @(posedge clk) begin
		req_s1 <= req;
	end

	// Clamp the count to the palette and classify the sample.
	always_comb begin
		count = color_count;
		if ({4'd0, color_count} > DEPTH_W) begin
			count = DEPTH_W[CNT_W-1:0];
		end
		if (count < CNT_W'(2)) begin
			count = CNT_W'(2);
		end
		s_ext   = {req_s1.sample[31], req_s1.sample};
		tol_ext = $signed({2'b00, tolerance});
		sum     = s_ext + tol_ext;
		if (req_s1.sample < black_level) begin
			cls = CLS_BLACK;
		end else if (s_ext >= tol_ext) begin
			cls = CLS_LAST;
		end else if (s_ext <= -tol_ext) begin
			cls = CLS_FIRST;
		end else begin
			cls = CLS_BLEND;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s2.vld <= 1'b0;
		end else begin
			ctl_s2.vld   <= vld_s1;
			ctl_s2.wr    <= (req_s1.func == FUNC_WRITE);
			ctl_s2.idx   <= req_s1.entry_index;
			ctl_s2.color <= req_s1.entry_color;
			ctl_s2.cls   <= cls;
			ctl_s2.last  <= count - CNT_W'(1);
		end
	end

	always_ff @(posedge clk) begin
		u_s2      <= sum[31:0];
		cnt_m1_s2 <= count - CNT_W'(1);
	end

	// Position scaled by the number of palette segments.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s3.vld <= 1'b0;
		end else begin
			ctl_s3 <= ctl_s2;
		end
	end

	always_ff @(posedge clk) begin
		prod_s3 <= {5'd0, u_s2} * 37'(cnt_m1_s2);
	end

endmodule

[rtl/core/vtpc_div_step.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpc_div_step
// One restoring division step: produces one quotient bit per stage.
// ----------------------------------------------------------------------------
module vtpc_div_step (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vtpc_pkg::vtpc_ctl_t          ctl_in,
	input  logic [31:0]                  rem_in,
	input  logic [vtpc_pkg::QUOT_W-1:0]  word_in,
	input  logic [31:0]                  divisor,
	output vtpc_pkg::vtpc_ctl_t          ctl_s1,
	output logic [31:0]                  rem_s1,
	output logic [vtpc_pkg::QUOT_W-1:0]  word_s1
);
	import vtpc_pkg::*;

	logic [32:0] trial;
	logic [32:0] diff;
	logic        fits;

	// Shift in the next dividend bit and subtract when the divisor fits.
	always_comb begin
		trial = {rem_in, word_in[QUOT_W-1]};
		diff  = trial - {1'b0, divisor};
		fits  = (trial >= {1'b0, divisor});
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1.vld <= 1'b0;
		end else begin
			ctl_s1 <= ctl_in;
		end
	end

	always_ff @(posedge clk) begin
		rem_s1  <= fits ? diff[31:0] : trial[31:0];
		word_s1 <= {word_in[QUOT_W-2:0], fits};
	end

endmodule

[rtl/core/vtpc_palette.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// vtpc_palette
// Palette memory, entry reads and the per-channel linear blend.
// ----------------------------------------------------------------------------
module vtpc_palette #(
	parameter int PALETTE_DEPTH = 16
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  vtpc_pkg::vtpc_ctl_t          ctl_in,
	input  logic [vtpc_pkg::QUOT_W-1:0]  quot,
	output logic                         result_valid,
	output vtpc_pkg::vtpc_out_t          result
);
	import vtpc_pkg::*;

	localparam int         AW      = (PALETTE_DEPTH > 2) ? $clog2(PALETTE_DEPTH) : 1;
	localparam logic [8:0] DEPTH_W = 9'(PALETTE_DEPTH);

	logic [31:0] mem [PALETTE_DEPTH];

	logic [CNT_W-1:0] base;
	logic [8:0]       sel_a;
	logic [8:0]       sel_b;
	logic [8:0]       wr_sel;

	logic              vld_s1;
	logic              map_s1;
	logic [1:0]        cls_s1;
	logic [FRAC_W-1:0] frac_s1;
	logic [31:0]       ent_a_s1;
	logic [31:0]       ent_b_s1;

	logic [FRAC_W:0] w_hi;
	logic [FRAC_W:0] w_lo;
	logic [24:0]     mix [3];
	logic [31:0]     word;

	// Read addresses: the segment ends, or a palette end entry.
	always_comb begin
		base   = quot[QUOT_W-1:FRAC_W];
		wr_sel = {5'd0, ctl_in.idx};
		sel_b  = {4'd0, base + CNT_W'(1)};
		unique case (ctl_in.cls)
			CLS_BLEND: sel_a = {4'd0, base};
			CLS_LAST:  sel_a = {4'd0, ctl_in.last};
			default:   sel_a = 9'd0;
		endcase
	end

	// Writes and reads happen in request order at this one stage.
	always_ff @(posedge clk) begin
		if (ctl_in.vld && ctl_in.wr && (wr_sel < DEPTH_W)) begin
			mem[wr_sel[AW-1:0]] <= ctl_in.color;
		end
		ent_a_s1 <= mem[sel_a[AW-1:0]];
		ent_b_s1 <= mem[sel_b[AW-1:0]];
		cls_s1   <= ctl_in.cls;
		frac_s1  <= quot[FRAC_W-1:0];
		map_s1   <= !ctl_in.wr;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctl_in.vld;
		end
	end

	// Blend each color channel and pick the final word.
	always_comb begin
		w_hi = {1'b0, frac_s1};
		w_lo = 17'h10000 - w_hi;
		for (int c = 0; c < 3; c++) begin
			mix[c] = 25'(w_hi) * 25'(ent_b_s1[8*c +: 8])
				+ 25'(w_lo) * 25'(ent_a_s1[8*c +: 8]);
		end
		unique case (cls_s1)
			CLS_BLACK: word = BLACK_WORD;
			CLS_BLEND: word = {ALPHA_OPAQUE, mix[2][23:16], mix[1][23:16], mix[0][23:16]};
			default:   word = ent_a_s1;
		endcase
	end

	// Output register and strobe.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_valid <= 1'b0;
		end else begin
			result_valid <= vld_s1 && map_s1;
		end
	end

	always_ff @(posedge clk) begin
		result.red   <= word[7:0];
		result.green <= word[15:8];
		result.blue  <= word[23:16];
		result.alpha <= word[31:24];
	end

endmodule
